@@ sv/lap_timer_with_best_lap_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Lap timer assertion macros
// Shared property wrappers for the lap timer checkers.
// ----------------------------------------------------------------------------
`ifndef LAP_TIMER_WITH_BEST_LAP_UNIT_MACROS_SVH
`define LAP_TIMER_WITH_BEST_LAP_UNIT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define LAPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lap timer check failed");

// A stalled beat keeps its valid and its payload.
`define LAPT_ASSERT_HOLD(lbl, clk, rstn, vld, stl, sig) \
  `LAPT_ASSERT(lbl, clk, rstn, vld && stl |=> vld && $stable(sig))

`endif

@@ sv/laptmr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lap timer package
// Beat types, time split constants and fold weights.
// ----------------------------------------------------------------------------
package laptmr_pkg;

  localparam int unsigned StampW = 48;
  localparam int unsigned MinW   = 7;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MsW    = 10;

  typedef struct packed {
    logic [StampW-1:0] now_us;
    logic              barrier_event;
    logic [StampW-1:0] event_time_us;
    logic              clear;
  } in_beat_t;

  typedef struct packed {
    logic [MinW-1:0] elapsed_min;
    logic [SecW-1:0] elapsed_sec;
    logic [MsW-1:0]  elapsed_ms;
    logic            lap_valid;
    logic [MinW-1:0] lap_min;
    logic [SecW-1:0] lap_sec;
    logic [MsW-1:0]  lap_ms;
    logic            best_valid;
    logic [MinW-1:0] best_min;
    logic [SecW-1:0] best_sec;
    logic [MsW-1:0]  best_ms;
    logic            running;
  } out_beat_t;

  typedef struct packed {
    logic lap_valid;
    logic best_valid;
    logic running;
  } flag_t;

  // state snapshot stage plus ten split stages
  localparam int unsigned NumStages = 11;
  localparam int unsigned NumLane   = NumStages - 1;

  localparam longint unsigned UsPerS     = 64'd1000000;
  localparam longint unsigned SecPerMin  = 64'd60;
  // 99 minutes in microseconds: the display wraps here
  localparam longint unsigned TimeWrapUs = 64'd5940000000;

  // fold of the timestamp, one byte per partial product
  localparam int unsigned ChunkW = 8;
  localparam int unsigned WrapW  = 33;
  localparam int unsigned PairW  = 42;
  localparam int unsigned SumW   = 44;

  // quotient estimate of the folded sum by the wrap period
  localparam int unsigned     SumShift       = 20;
  localparam int unsigned     SumHiW         = SumW - SumShift;
  localparam int unsigned     RecipWrapShift = 24;
  localparam int unsigned     RecipWrapW     = 12;
  localparam longint unsigned RecipWrap      = (64'd1 << (SumShift + RecipWrapShift)) /
                                               TimeWrapUs;
  localparam int unsigned     ProdWrapW      = SumHiW + RecipWrapW;
  localparam int unsigned     RemW           = WrapW + 1;

  // whole seconds: divide by 64 by shift, then by 15625 by reciprocal
  localparam int unsigned     SecPreShift = 6;
  localparam int unsigned     SecXW       = WrapW - SecPreShift;
  localparam int unsigned     SecShift    = 41;
  localparam int unsigned     RecipSecW   = 28;
  localparam longint unsigned RecipSec    = (64'd1 << SecShift) / (UsPerS >> SecPreShift);
  localparam int unsigned     ProdSecW    = SecXW + RecipSecW;
  localparam int unsigned     QuotW       = 13;
  localparam int unsigned     RemSW       = 21;
  localparam int unsigned     MsRemW      = 20;

  // milliseconds: divide by 8 by shift, then by 125
  localparam int unsigned     MsPreShift = 3;
  localparam int unsigned     MsYW       = MsRemW - MsPreShift;
  localparam int unsigned     MsShift    = 24;
  localparam int unsigned     RecipMsW   = 18;
  localparam longint unsigned RecipMs    = ((64'd1 << MsShift) + 64'd124) / 64'd125;
  localparam int unsigned     ProdMsW    = MsYW + RecipMsW;

  // minutes: divide by 4 by shift, then by 15
  localparam int unsigned     MinPreShift = 2;
  localparam int unsigned     MinZW       = QuotW - MinPreShift;
  localparam int unsigned     MinShift    = 15;
  localparam int unsigned     RecipMinW   = 12;
  localparam longint unsigned RecipMin    = ((64'd1 << MinShift) + 64'd14) / 64'd15;
  localparam int unsigned     ProdMinW    = MinZW + RecipMinW;

  // 2^(8*idx) mod wrap period, evaluated at elaboration
  function automatic longint unsigned fold_weight(input int unsigned idx);
    longint unsigned acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < idx; i++) begin
      acc = (acc << ChunkW) % TimeWrapUs;
    end
    return acc;
  endfunction

endpackage

@@ sv/lap_timer_with_best_lap_unit.sv @@
// ----------------------------------------------------------------------------
// Lap timer with best lap
// Poll-driven stopwatch: elapsed, last lap and best lap in min/sec/ms.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake              Beat
//   in_*         in         in_valid_i/in_stall_o   laptmr_pkg::in_beat_t
//   out_*        out        out_valid_o/out_stall_i laptmr_pkg::out_beat_t
//
// One poll beat in, one result beat out, a new poll every cycle unless stalled.
// A beat passes the state update and time snapshot, then ten split stages
//   (fold mod 99 min, three reciprocal divides and two corrections).
// Rate is one beat per cycle while in_stall_o is low; the 48-bit subtract
//   plus best-lap compare in the state update is the only loop.
// Reset clears timer, lap and best state and empties the pipeline; no sweep.
// An output stall backs up stage by stage; in_stall_o rises only once all
//   eleven stages hold a beat.
// ----------------------------------------------------------------------------
module lap_timer_with_best_lap_unit #(
  parameter int unsigned TimeBits = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  laptmr_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output laptmr_pkg::out_beat_t out_data_o
);
  import laptmr_pkg::*;

  logic [NumStages-1:0] en;
  logic                 accept;
  flag_t                flags_d, flags_out;
  logic [TimeBits-1:0]  t_elapsed, t_lap, t_best;
  logic [MinW-1:0]      el_min, lap_min, best_min;
  logic [SecW-1:0]      el_sec, lap_sec, best_sec;
  logic [MsW-1:0]       el_ms, lap_ms, best_ms;

  // poll taken: state moves only on a real beat
  assign accept = in_valid_i & ~in_stall_o;

  laptmr_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .flags_i     (flags_d),
    .en_o        (en),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .flags_o     (flags_out)
  );

  laptmr_state #(.TimeBits(TimeBits)) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .load_i      (en[0]),
    .beat_i      (in_data_i),
    .t_elapsed_o (t_elapsed),
    .t_lap_o     (t_lap),
    .t_best_o    (t_best),
    .flags_o     (flags_d)
  );

  // three identical split lanes, stepped by the same stage enables
  laptmr_split #(.TimeBits(TimeBits)) u_split_elapsed (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:1]),
    .t_i   (t_elapsed),
    .min_o (el_min),
    .sec_o (el_sec),
    .ms_o  (el_ms)
  );

  laptmr_split #(.TimeBits(TimeBits)) u_split_lap (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:1]),
    .t_i   (t_lap),
    .min_o (lap_min),
    .sec_o (lap_sec),
    .ms_o  (lap_ms)
  );

  laptmr_split #(.TimeBits(TimeBits)) u_split_best (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:1]),
    .t_i   (t_best),
    .min_o (best_min),
    .sec_o (best_sec),
    .ms_o  (best_ms)
  );

  always_comb begin
    out_data_o             = '0;
    out_data_o.elapsed_min = el_min;
    out_data_o.elapsed_sec = el_sec;
    out_data_o.elapsed_ms  = el_ms;
    out_data_o.lap_valid   = flags_out.lap_valid;
    out_data_o.lap_min     = lap_min;
    out_data_o.lap_sec     = lap_sec;
    out_data_o.lap_ms      = lap_ms;
    out_data_o.best_valid  = flags_out.best_valid;
    out_data_o.best_min    = best_min;
    out_data_o.best_sec    = best_sec;
    out_data_o.best_ms     = best_ms;
    out_data_o.running     = flags_out.running;
  end

endmodule

@@ sv/laptmr_state.sv @@
// ----------------------------------------------------------------------------
// Lap timer state update
// Clear, elapsed, lap and best-lap update per poll, plus time snapshot.
// ----------------------------------------------------------------------------
module laptmr_state #(
  parameter int unsigned TimeBits = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 load_i,
  input  laptmr_pkg::in_beat_t beat_i,
  output logic [TimeBits-1:0]  t_elapsed_o,
  output logic [TimeBits-1:0]  t_lap_o,
  output logic [TimeBits-1:0]  t_best_o,
  output laptmr_pkg::flag_t    flags_o
);
  import laptmr_pkg::*;

  logic                active_q, active_d, active_c;
  logic                burst_q, burst_d, burst_c;
  logic                lap_ok_q, lap_ok_d, lap_ok_c;
  logic                best_ok_q, best_ok_d, best_ok_c;
  logic [TimeBits-1:0] start_q, start_d;
  logic [TimeBits-1:0] elapsed_q, elapsed_d, elapsed_c;
  logic [TimeBits-1:0] lap_q, lap_d, lap_c;
  logic [TimeBits-1:0] best_q, best_d, best_c;
  logic [TimeBits-1:0] now_t, edge_t, lap_new;

  always_comb begin
    now_t   = TimeBits'(beat_i.now_us);
    edge_t  = TimeBits'(beat_i.event_time_us);
    lap_new = edge_t - start_q;

    // clear acts first
    active_c  = active_q  & ~beat_i.clear;
    burst_c   = burst_q   & ~beat_i.clear;
    lap_ok_c  = lap_ok_q  & ~beat_i.clear;
    best_ok_c = best_ok_q & ~beat_i.clear;
    elapsed_c = beat_i.clear ? '0 : elapsed_q;
    lap_c     = beat_i.clear ? '0 : lap_q;
    best_c    = beat_i.clear ? '0 : best_q;

    active_d  = active_c;
    burst_d   = burst_c;
    lap_ok_d  = lap_ok_c;
    best_ok_d = best_ok_c;
    start_d   = start_q;
    lap_d     = lap_c;
    best_d    = best_c;
    elapsed_d = active_c ? (now_t - start_q) : elapsed_c;

    if (beat_i.barrier_event) begin
      if (!burst_c) begin
        burst_d = 1'b1;
        if (active_c) begin
          lap_d    = lap_new;
          lap_ok_d = 1'b1;
          if (!best_ok_c || (lap_new < best_c)) begin
            best_d    = lap_new;
            best_ok_d = 1'b1;
          end
        end
        start_d  = edge_t;
        active_d = 1'b1;
      end
    end else begin
      burst_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      burst_q   <= 1'b0;
      lap_ok_q  <= 1'b0;
      best_ok_q <= 1'b0;
      start_q   <= '0;
      elapsed_q <= '0;
      lap_q     <= '0;
      best_q    <= '0;
    end else if (accept_i) begin
      active_q  <= active_d;
      burst_q   <= burst_d;
      lap_ok_q  <= lap_ok_d;
      best_ok_q <= best_ok_d;
      start_q   <= start_d;
      elapsed_q <= elapsed_d;
      lap_q     <= lap_d;
      best_q    <= best_d;
    end
  end

  // snapshot for the split lanes; missing lap or best shows as zero
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      t_elapsed_o <= elapsed_d;
      t_lap_o     <= lap_ok_d ? lap_d : '0;
      t_best_o    <= best_ok_d ? best_d : '0;
    end
  end

  assign flags_o = '{lap_valid: lap_ok_d, best_valid: best_ok_d, running: active_d};

endmodule

@@ sv/laptmr_split.sv @@
// ----------------------------------------------------------------------------
// Lap timer time split lane
// Microseconds to minutes mod 99, seconds and milliseconds in ten stages.
// ----------------------------------------------------------------------------
module laptmr_split #(
  parameter int unsigned TimeBits = 48
) (
  input  logic                                clk_i,
  input  logic [laptmr_pkg::NumLane-1:0]      en_i,
  input  logic [TimeBits-1:0]                 t_i,
  output logic [laptmr_pkg::MinW-1:0]         min_o,
  output logic [laptmr_pkg::SecW-1:0]         sec_o,
  output logic [laptmr_pkg::MsW-1:0]          ms_o
);
  import laptmr_pkg::*;

  localparam int unsigned NumChunks = (TimeBits + ChunkW - 1) / ChunkW;
  localparam int unsigned NumPairs  = (NumChunks + 1) / 2;
  localparam int unsigned PadW      = NumPairs * 2 * ChunkW;

  logic [PadW-1:0]       t_pad;
  logic [PairW-1:0]      pair_d [NumPairs];
  logic [PairW-1:0]      pair_q [NumPairs];
  logic [SumW-1:0]       sum_d, sum_q, sum3_q;
  logic [ProdWrapW-1:0]  prod_wrap;
  logic [RecipWrapW-1:0] qw_q;
  logic [SumW-1:0]       rem_full;
  logic [RemW-1:0]       r0_q;
  logic [WrapW-1:0]      u_d, u_q, u6_q;
  logic [ProdSecW-1:0]   prod_sec;
  logic [QuotW-1:0]      qs_q, qs7_q;
  logic [WrapW-1:0]      rs_full;
  logic [RemSW-1:0]      rs_q;
  logic [MsRemW-1:0]     rc_d, rc_q;
  logic [QuotW-1:0]      qc_d, qc_q, qc9_q;
  logic [ProdMsW-1:0]    prod_ms;
  logic [ProdMinW-1:0]   prod_min;
  logic [MsW-1:0]        ms9_q, ms_q;
  logic [MinW-1:0]       min9_q, min_q;
  logic [QuotW-1:0]      sec_full;
  logic [SecW-1:0]       sec_q;

  assign t_pad = PadW'(t_i);

  // fold: each byte times its weight 2^(8k) mod 99 min, two bytes per pair
  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    localparam longint unsigned WLo = fold_weight(2 * p);
    localparam longint unsigned WHi = fold_weight(2 * p + 1);
    assign pair_d[p] = PairW'(t_pad[2*p*ChunkW +: ChunkW]) * PairW'(WLo) +
                       PairW'(t_pad[(2*p+1)*ChunkW +: ChunkW]) * PairW'(WHi);
  end

  always_comb begin
    sum_d = '0;
    for (int unsigned p = 0; p < NumPairs; p++) begin
      sum_d = sum_d + SumW'(pair_q[p]);
    end
  end

  // quotient estimate is low by at most one
  assign prod_wrap = ProdWrapW'(sum_q[SumW-1:SumShift]) * ProdWrapW'(RecipWrap);
  assign rem_full  = sum3_q - SumW'(qw_q) * SumW'(TimeWrapUs);
  assign u_d       = (r0_q >= RemW'(TimeWrapUs)) ? WrapW'(r0_q - RemW'(TimeWrapUs))
                                                 : r0_q[WrapW-1:0];

  assign prod_sec = ProdSecW'(u_q[WrapW-1:SecPreShift]) * ProdSecW'(RecipSec);
  assign rs_full  = u6_q - WrapW'(qs_q) * WrapW'(UsPerS);

  always_comb begin
    if (rs_q >= RemSW'(UsPerS)) begin
      rc_d = MsRemW'(rs_q - RemSW'(UsPerS));
      qc_d = qs7_q + QuotW'(1);
    end else begin
      rc_d = rs_q[MsRemW-1:0];
      qc_d = qs7_q;
    end
  end

  assign prod_ms  = ProdMsW'(rc_q[MsRemW-1:MsPreShift]) * ProdMsW'(RecipMs);
  assign prod_min = ProdMinW'(qc_q[QuotW-1:MinPreShift]) * ProdMinW'(RecipMin);
  assign sec_full = qc9_q - QuotW'(min9_q) * QuotW'(SecPerMin);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) pair_q <= pair_d;
    if (en_i[1]) sum_q <= sum_d;
    if (en_i[2]) begin
      qw_q   <= prod_wrap[RecipWrapShift +: RecipWrapW];
      sum3_q <= sum_q;
    end
    if (en_i[3]) r0_q <= rem_full[RemW-1:0];
    if (en_i[4]) u_q <= u_d;
    if (en_i[5]) begin
      qs_q <= prod_sec[SecShift +: QuotW];
      u6_q <= u_q;
    end
    if (en_i[6]) begin
      rs_q  <= rs_full[RemSW-1:0];
      qs7_q <= qs_q;
    end
    if (en_i[7]) begin
      rc_q <= rc_d;
      qc_q <= qc_d;
    end
    if (en_i[8]) begin
      ms9_q  <= prod_ms[MsShift +: MsW];
      min9_q <= prod_min[MinShift +: MinW];
      qc9_q  <= qc_q;
    end
    if (en_i[9]) begin
      ms_q  <= ms9_q;
      min_q <= min9_q;
      sec_q <= sec_full[SecW-1:0];
    end
  end

  assign min_o = min_q;
  assign sec_o = sec_q;
  assign ms_o  = ms_q;

endmodule

@@ sv/laptmr_flow.sv @@
// ----------------------------------------------------------------------------
// Lap timer pipeline flow control
// Per-stage valid bits, stage enables and the flag bits of each beat.
// ----------------------------------------------------------------------------
module laptmr_flow (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             out_stall_i,
  input  laptmr_pkg::flag_t                flags_i,
  output logic [laptmr_pkg::NumStages-1:0] en_o,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output laptmr_pkg::flag_t                flags_o
);
  import laptmr_pkg::*;

  logic [NumStages-1:0] v_q, v_in, ready;
  flag_t                flags_q [NumStages];

  // a stage moves when it is empty or the one after it moves
  assign ready[NumStages-1] = ~v_q[NumStages-1] | ~out_stall_i;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_ready
    assign ready[k] = ~v_q[k] | ready[k+1];
  end

  assign v_in = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_in & ready) | (v_q & ~ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) flags_q[0] <= flags_i;
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_flags
    always_ff @(posedge clk_i) begin
      if (ready[k]) flags_q[k] <= flags_q[k-1];
    end
  end

  assign en_o        = ready;
  assign in_stall_o  = ~ready[0];
  assign out_valid_o = v_q[NumStages-1];
  assign flags_o     = flags_q[NumStages-1];

endmodule

@@ sv/laptmr_checker.sv @@
// ----------------------------------------------------------------------------
// Lap timer port checker
// Port-level checks on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "lap_timer_with_best_lap_unit_macros.svh"

module laptmr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_stall_i,
  input laptmr_pkg::out_beat_t out_data_i
);
  import laptmr_pkg::*;

  `LAPT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_stall_i, out_data_i)
  `LAPT_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)
  `LAPT_ASSERT(a_no_lap_zero, clk_i, rst_ni,
    out_valid_i && !out_data_i.lap_valid |->
      out_data_i.lap_min == 0 && out_data_i.lap_sec == 0 && out_data_i.lap_ms == 0 &&
      out_data_i.best_min == 0 && out_data_i.best_sec == 0 && out_data_i.best_ms == 0)
  `LAPT_ASSERT(a_flag_order, clk_i, rst_ni,
    out_valid_i |-> out_data_i.best_valid == out_data_i.lap_valid &&
      (!out_data_i.lap_valid || out_data_i.running))
  `LAPT_ASSERT(a_digit_range, clk_i, rst_ni,
    out_valid_i |-> out_data_i.elapsed_min < 99 && out_data_i.elapsed_sec < 60 &&
      out_data_i.elapsed_ms < 1000 && out_data_i.best_sec < 60 && out_data_i.lap_ms < 1000)

endmodule

bind lap_timer_with_best_lap_unit laptmr_checker u_laptmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

@@ tb/lap_result_checker.sv @@
// ----------------------------------------------------------------------------
// Lap timer result checker
// Watches both channels, predicts each result beat from the accepted poll
// beats and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module lap_result_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  laptmr_pkg::in_beat_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  laptmr_pkg::out_beat_t out_data_i,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import laptmr_pkg::*;

  localparam longint unsigned UsPerSec    = 64'd1000000;
  localparam longint unsigned UsPerMsec   = 64'd1000;
  localparam longint unsigned SecsPerMin  = 64'd60;
  localparam longint unsigned MinutesWrap = 64'd99;

  typedef struct packed {
    logic [laptmr_pkg::MinW-1:0] mins;
    logic [laptmr_pkg::SecW-1:0] secs;
    logic [laptmr_pkg::MsW-1:0]  msecs;
  } shown_time_t;

  // predicted timer state
  logic                          timing_on;
  logic                          in_burst;
  logic [laptmr_pkg::StampW-1:0] start_us;
  logic [laptmr_pkg::StampW-1:0] elapsed_us;
  logic [laptmr_pkg::StampW-1:0] lap_us;
  logic                          lap_ok;
  logic [laptmr_pkg::StampW-1:0] best_us;
  logic                          best_ok;

  laptmr_pkg::out_beat_t expected_results[$];

  function automatic shown_time_t split_us(input logic [laptmr_pkg::StampW-1:0] t,
                                           input logic show);
    longint unsigned rest;
    shown_time_t     d;
    d = '0;
    if (show) begin
      rest    = t;
      d.msecs = MsW'((rest % UsPerSec) / UsPerMsec);
      rest    = rest / UsPerSec;
      d.secs  = SecW'(rest % SecsPerMin);
      rest    = rest / SecsPerMin;
      d.mins  = MinW'(rest % MinutesWrap);
    end
    return d;
  endfunction

  // clear, then elapsed from the old start, then the barrier edge
  function automatic laptmr_pkg::out_beat_t predict_poll(input laptmr_pkg::in_beat_t poll);
    laptmr_pkg::out_beat_t res;
    shown_time_t           e_t;
    shown_time_t           l_t;
    shown_time_t           b_t;
    if (poll.clear) begin
      timing_on  = 1'b0;
      in_burst   = 1'b0;
      elapsed_us = '0;
      lap_us     = '0;
      lap_ok     = 1'b0;
      best_us    = '0;
      best_ok    = 1'b0;
    end
    if (timing_on) elapsed_us = poll.now_us - start_us;
    if (poll.barrier_event) begin
      if (!in_burst) begin
        in_burst = 1'b1;
        if (timing_on) begin
          lap_us = poll.event_time_us - start_us;
          lap_ok = 1'b1;
          if (!best_ok || lap_us < best_us) begin
            best_us = lap_us;
            best_ok = 1'b1;
          end
        end
        start_us  = poll.event_time_us;
        timing_on = 1'b1;
      end
    end else begin
      in_burst = 1'b0;
    end
    e_t = split_us(elapsed_us, 1'b1);
    l_t = split_us(lap_us, lap_ok);
    b_t = split_us(best_us, best_ok);
    res.elapsed_min = e_t.mins;
    res.elapsed_sec = e_t.secs;
    res.elapsed_ms  = e_t.msecs;
    res.lap_valid   = lap_ok;
    res.lap_min     = l_t.mins;
    res.lap_sec     = l_t.secs;
    res.lap_ms      = l_t.msecs;
    res.best_valid  = best_ok;
    res.best_min    = b_t.mins;
    res.best_sec    = b_t.secs;
    res.best_ms     = b_t.msecs;
    res.running     = timing_on;
    return res;
  endfunction

  task automatic check_field(input string fname, input longint unsigned want,
                             input longint unsigned got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_cnt_o++;
    end
  endtask

  task automatic compare_beat(input laptmr_pkg::out_beat_t want,
                              input laptmr_pkg::out_beat_t got);
    check_field("elapsed_min", want.elapsed_min, got.elapsed_min);
    check_field("elapsed_sec", want.elapsed_sec, got.elapsed_sec);
    check_field("elapsed_ms",  want.elapsed_ms,  got.elapsed_ms);
    check_field("lap_valid",   want.lap_valid,   got.lap_valid);
    check_field("lap_min",     want.lap_min,     got.lap_min);
    check_field("lap_sec",     want.lap_sec,     got.lap_sec);
    check_field("lap_ms",      want.lap_ms,      got.lap_ms);
    check_field("best_valid",  want.best_valid,  got.best_valid);
    check_field("best_min",    want.best_min,    got.best_min);
    check_field("best_sec",    want.best_sec,    got.best_sec);
    check_field("best_ms",     want.best_ms,     got.best_ms);
    check_field("running",     want.running,     got.running);
  endtask

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_on  = 1'b0;
      in_burst   = 1'b0;
      start_us   = '0;
      elapsed_us = '0;
      lap_us     = '0;
      lap_ok     = 1'b0;
      best_us    = '0;
      best_ok    = 1'b0;
      expected_results.delete();
    end else begin
      // result side first: a beat out always belongs to an earlier poll
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result beat with none expected, actual %h", $time, out_data_i);
          mismatch_cnt_o++;
        end else begin
          compare_beat(expected_results.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_poll(in_data_i));
    end
    pending_o = expected_results.size();
  end

endmodule

@@ tb/tb_lap_timer_with_best_lap_unit.sv @@
// ----------------------------------------------------------------------------
// Lap timer with best lap testbench
// Drives poll beats into the block, directed first and then random
// well-formed lap sequences mixed with noise, with random gaps and output
// stalls; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_lap_timer_with_best_lap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandPolls  = 1650;
  localparam int unsigned CycleLimit = 500000;
  // pipeline is 11 deep; leave a margin for stray beats
  localparam int unsigned TailCycles = 30;
  localparam int unsigned MaxIdle    = 18;

  localparam logic [laptmr_pkg::StampW-1:0] AllOnes = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  laptmr_pkg::in_beat_t  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  laptmr_pkg::out_beat_t out_data_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt  = 0;

  // idling controls: a quiet stretch means back-to-back beats
  logic        src_quiet  = 1'b0;
  logic        sink_quiet = 1'b0;
  int unsigned sink_hold  = 0;
  int unsigned sink_beats = 0;

  always #4 clk_i = ~clk_i;

  lap_timer_with_best_lap_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  lap_result_checker u_result_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL lap_timer_with_best_lap_unit");
      $finish;
    end
  end

  // Result side: after every accepted beat draw how long to stall before
  // taking the next one. Stall also covers idle cycles, so it lands on every
  // phase of the pipeline.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        sink_beats++;
        if (sink_beats % 100 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
        sink_hold = sink_quiet ? 0 : $urandom_range(0, MaxIdle);
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      out_stall_i <= (sink_hold != 0);
    end
  end

  function automatic logic [laptmr_pkg::StampW-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[laptmr_pkg::StampW-1:0];
  endfunction

  // Start of a fresh run of polls: near zero, anywhere, or just below the wrap.
  function automatic logic [laptmr_pkg::StampW-1:0] fresh_base();
    logic [laptmr_pkg::StampW-1:0] b;
    case ($urandom_range(0, 3))
      0, 1: begin
        b = $urandom_range(0, 1000000);
      end
      2: begin
        b = rand_stamp();
      end
      default: begin
        b = AllOnes - $urandom_range(0, 1000000000);
      end
    endcase
    return b;
  endfunction

  function automatic laptmr_pkg::in_beat_t make_poll(
    input logic [laptmr_pkg::StampW-1:0] now_us,
    input logic                          edge_seen,
    input logic [laptmr_pkg::StampW-1:0] edge_us,
    input logic                          clr
  );
    laptmr_pkg::in_beat_t p;
    p.now_us        = now_us;
    p.barrier_event = edge_seen;
    p.event_time_us = edge_us;
    p.clear         = clr;
    return p;
  endfunction

  // One poll beat: optional idle gap, then hold valid and payload until taken.
  // Called at the edge that took the previous beat, so valid stays high with
  // no gap and only one assignment lands in that step.
  task automatic send_poll(input laptmr_pkg::in_beat_t beat);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    logic [laptmr_pkg::StampW-1:0] t_now;
    logic [laptmr_pkg::StampW-1:0] now_v;
    logic [laptmr_pkg::StampW-1:0] ev_v;
    logic                          edge_v;
    logic                          clr_v;
    int unsigned                   step;
    int unsigned                   burst_left;
    int unsigned                   pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed polls ----
    send_poll(make_poll(0, 1'b0, 0, 1'b0));                 // idle, nothing shown
    send_poll(make_poll(1500, 1'b1, 1000, 1'b0));           // first edge starts timing
    send_poll(make_poll(2000, 1'b1, 1900, 1'b0));           // same burst, ignored
    send_poll(make_poll(3000, 1'b0, 0, 1'b0));              // re-arm
    send_poll(make_poll(61002000, 1'b1, 61001000, 1'b0));   // lap 1:01.000
    send_poll(make_poll(61500000, 1'b0, 0, 1'b0));
    send_poll(make_poll(92000000, 1'b1, 91500123, 1'b0));   // shorter lap, new best
    send_poll(make_poll(92100000, 1'b0, 0, 1'b0));
    // lap of exactly 99 minutes: display wraps to zero, best kept
    send_poll(make_poll(64'd6031600000, 1'b1, 64'd6031500123, 1'b0));
    send_poll(make_poll(64'd6031700000, 1'b0, 0, 1'b0));
    send_poll(make_poll(AllOnes, 1'b0, 0, 1'b0));           // huge elapsed time
    send_poll(make_poll(100, 1'b1, 5, 1'b1));               // clear with edge: start, no lap
    send_poll(make_poll(3, 1'b0, 0, 1'b0));                 // clock behind start
    send_poll(make_poll(10, 1'b1, 0, 1'b0));                // lap wraps to a huge value
    send_poll(make_poll(20, 1'b0, 0, 1'b0));
    send_poll(make_poll(30, 1'b1, 4, 1'b0));                // 4 us lap beats it
    send_poll(make_poll(AllOnes, 1'b0, AllOnes, 1'b1));     // clear alone, fields all ones
    send_poll(make_poll(AllOnes, 1'b1, AllOnes, 1'b0));     // start at top of range
    send_poll(make_poll(0, 1'b0, 0, 1'b0));
    send_poll(make_poll(5, 1'b1, 0, 1'b0));                 // lap across the wrap, 1 us
    send_poll(make_poll(7, 1'b0, 0, 1'b1));                 // clear alone

    // ---- random polls ----
    // Mostly a forward-running clock with barrier bursts, so laps and best
    // laps build up; the rest is unrelated noise.
    t_now      = fresh_base();
    burst_left = 0;
    for (int unsigned n = 0; n < RandPolls; n++) begin
      if (n % 100 == 0) src_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 12) begin
        now_v  = rand_stamp();
        ev_v   = rand_stamp();
        edge_v = $urandom_range(0, 1);
        clr_v  = ($urandom_range(0, 7) == 0);
      end else begin
        clr_v = ($urandom_range(0, 49) == 0);
        if (clr_v) t_now = fresh_base();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          step = $urandom_range(1, 3000000);
        end else if (pick < 95) begin
          step = $urandom_range(0, 200000000);
        end else begin
          step = $urandom;                                  // up to about 71 minutes
        end
        t_now = t_now + step;
        if (burst_left != 0) begin
          edge_v = 1'b1;
          burst_left--;
        end else if ($urandom_range(0, 99) < 20) begin
          edge_v     = 1'b1;
          burst_left = $urandom_range(0, 2);
        end else begin
          edge_v = 1'b0;
        end
        // edge latched somewhere since the last poll; junk when no edge
        ev_v  = edge_v ? t_now - $urandom_range(0, step) : rand_stamp();
        now_v = t_now;
      end
      send_poll(make_poll(now_v, edge_v, ev_v, clr_v));
    end
    in_valid_i <= 1'b0;

    // ---- drain and verdict ----
    // one edge first so the count already holds the last poll
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS lap_timer_with_best_lap_unit");
    end else begin
      $display("FAIL lap_timer_with_best_lap_unit");
    end
    $finish;
  end

endmodule

@@ lap_timer_with_best_lap_unit.f @@
+incdir+sv
sv/laptmr_pkg.sv
sv/laptmr_state.sv
sv/laptmr_split.sv
sv/laptmr_flow.sv
sv/lap_timer_with_best_lap_unit.sv
sv/laptmr_checker.sv
tb/lap_result_checker.sv
tb/tb_lap_timer_with_best_lap_unit.sv
